### rtl/core/dsfw_pkg.sv
`timescale 1ns / 1ps
package dsfw_pkg;

    localparam int CHANNELS   = 8;
    localparam int CODE_BITS  = 12;
    localparam int FRAME_BITS = 16;
    localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNT_W      = 5;
    localparam int PROD_W     = 31;
    localparam int FULL_W     = 15;
    localparam int POS_W      = $clog2(FRAME_BITS);
    localparam int CMD_DEPTH  = 2;
    localparam int CMD_PTR_W  = 1;

    localparam logic [3:0]           FRAME_HEADER = 4'b0011;
    localparam logic [CODE_BITS-1:0] CODE_MAX     = {CODE_BITS{1'b1}};

    localparam logic [1:0] ST_SENT  = 2'd0;
    localparam logic [1:0] ST_SAME  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam logic [1:0] REG_CHANNEL_COUNT = 2'd0;
    localparam logic [1:0] REG_REFERENCE_MV  = 2'd1;
    localparam logic [1:0] REG_RESOLUTION    = 2'd2;
    localparam logic [1:0] REG_RAW_MODE      = 2'd3;

    typedef struct packed {
        logic [3:0]  channel;
        logic [15:0] level;
    } t_in_item;

    typedef struct packed {
        logic       carries_bit;
        logic [1:0] status;
        logic       serial_bit;
        logic [3:0] bit_position;
        logic       clamped;
        logic       final_res;
    } t_result;

    typedef struct packed {
        logic [3:0]  channel_count;
        logic [15:0] reference_mv;
        logic [3:0]  resolution_bits;
        logic        raw_code_mode;
    } t_cfg;

    typedef struct packed {
        logic [1:0]        status;
        logic [PROD_W-1:0] value;
    } t_cmd;

endpackage

### rtl/core/dsfw_front.sv
`timescale 1ns / 1ps
module dsfw_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dsfw_pkg::t_cfg     i_cfg,
    input  logic               i_push,
    input  dsfw_pkg::t_in_item i_item,
    input  logic               i_q_full,
    output logic               o_q_wr,
    output dsfw_pkg::t_cmd     o_cmd
);
    import dsfw_pkg::*;

    logic [15:0]       r_last [CHANNELS];
    logic [CNT_W-1:0]  limit;
    logic              in_range;
    logic              unchanged;
    logic [CH_W-1:0]   ch_idx;
    logic [FULL_W-1:0] full_scale;
    logic [PROD_W-1:0] product;

    assign limit = ({1'b0, i_cfg.channel_count} > CNT_W'(CHANNELS)) ?
                   CNT_W'(CHANNELS) : {1'b0, i_cfg.channel_count};
    assign in_range   = {1'b0, i_item.channel} < limit;
    assign ch_idx     = i_item.channel[CH_W-1:0];
    assign unchanged  = r_last[ch_idx] == i_item.level;
    assign full_scale = FULL_W'((16'd1 << i_cfg.resolution_bits) - 16'd1);
    assign product    = PROD_W'(i_item.level) * PROD_W'(full_scale);

    assign o_q_wr = i_push && !i_q_full;

    always_comb begin
        o_cmd.value = i_cfg.raw_code_mode ? PROD_W'(i_item.level) : product;
        if (!in_range) begin
            o_cmd.status = ST_RANGE;
        end else if (unchanged) begin
            o_cmd.status = ST_SAME;
        end else begin
            o_cmd.status = ST_SENT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_last[i] <= '0;
            end
        end else if (o_q_wr && in_range && !unchanged) begin
            r_last[ch_idx] <= i_item.level;
        end
    end

endmodule

### rtl/core/dsfw_fifo.sv
`timescale 1ns / 1ps
module dsfw_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  dsfw_pkg::t_cmd i_data,
    input  logic           i_rd,
    output dsfw_pkg::t_cmd o_data,
    output logic           o_full,
    output logic           o_empty
);
    import dsfw_pkg::*;

    t_cmd                 r_mem [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] r_wptr;
    logic [CMD_PTR_W-1:0] r_rptr;
    logic [CMD_PTR_W:0]   r_count;

    assign o_full  = r_count == (CMD_PTR_W + 1)'(CMD_DEPTH);
    assign o_empty = r_count == '0;
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_wr) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_rd) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_wr && !i_rd) begin
                r_count <= r_count + 1'b1;
            end else if (i_rd && !i_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### rtl/core/dsfw_back.sv
`timescale 1ns / 1ps
module dsfw_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dsfw_pkg::t_cfg    i_cfg,
    input  dsfw_pkg::t_cmd    i_cmd,
    input  logic              i_q_empty,
    output logic              o_q_rd,
    output dsfw_pkg::t_result o_result,
    output logic              o_valid,
    input  logic              i_pop
);
    import dsfw_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_DIV   = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;

    logic [1:0]            r_state;
    logic [15:0]           r_rem;
    logic [CODE_BITS-1:0]  r_dlow;
    logic [3:0]            r_cnt;
    logic [FRAME_BITS-1:0] r_frame;
    logic [POS_W-1:0]      r_pos;
    logic                  r_clamp;
    logic                  r_out_valid;
    t_result               r_out;

    logic [15:0]           ref_eff;
    logic                  slot_free;
    logic [16:0]           trial;
    logic                  ge;
    logic                  too_big;
    logic                  raw_big;
    logic                  load_out;

    assign ref_eff   = (i_cfg.reference_mv == '0) ? 16'd1 : i_cfg.reference_mv;
    assign slot_free = !r_out_valid || i_pop;
    assign trial     = {r_rem, r_dlow[CODE_BITS-1]};
    assign ge        = trial >= {1'b0, ref_eff};
    assign too_big   = i_cmd.value >= {3'b000, ref_eff, {CODE_BITS{1'b0}}};
    assign raw_big   = i_cmd.value[15:CODE_BITS] != '0;

    assign o_q_rd   = (r_state == S_IDLE) && !i_q_empty &&
                      ((i_cmd.status != ST_SENT) ? slot_free : 1'b1);
    assign load_out = ((r_state == S_IDLE) && o_q_rd && (i_cmd.status != ST_SENT)) ||
                      ((r_state == S_SHIFT) && slot_free);
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_q_rd) begin
                        if (i_cmd.status != ST_SENT) begin
                            r_out.carries_bit  <= 1'b0;
                            r_out.status       <= i_cmd.status;
                            r_out.serial_bit   <= 1'b0;
                            r_out.bit_position <= '0;
                            r_out.clamped      <= 1'b0;
                            r_out.final_res    <= 1'b1;
                        end else if (i_cfg.raw_code_mode) begin
                            r_clamp <= raw_big;
                            r_frame <= {FRAME_HEADER,
                                        raw_big ? CODE_MAX : i_cmd.value[CODE_BITS-1:0]};
                            r_pos   <= POS_W'(FRAME_BITS - 1);
                            r_state <= S_SHIFT;
                        end else if (too_big) begin
                            r_clamp <= 1'b1;
                            r_frame <= {FRAME_HEADER, CODE_MAX};
                            r_pos   <= POS_W'(FRAME_BITS - 1);
                            r_state <= S_SHIFT;
                        end else begin
                            r_rem   <= i_cmd.value[CODE_BITS+15:CODE_BITS];
                            r_dlow  <= i_cmd.value[CODE_BITS-1:0];
                            r_cnt   <= 4'(CODE_BITS - 1);
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    r_rem  <= ge ? 16'(trial - {1'b0, ref_eff}) : trial[15:0];
                    r_dlow <= {r_dlow[CODE_BITS-2:0], ge};
                    r_cnt  <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_clamp <= 1'b0;
                        r_frame <= {FRAME_HEADER, r_dlow[CODE_BITS-2:0], ge};
                        r_pos   <= POS_W'(FRAME_BITS - 1);
                        r_state <= S_SHIFT;
                    end
                end
                S_SHIFT: begin
                    if (slot_free) begin
                        r_out.carries_bit  <= 1'b1;
                        r_out.status       <= ST_SENT;
                        r_out.serial_bit   <= r_frame[FRAME_BITS-1];
                        r_out.bit_position <= r_pos;
                        r_out.clamped      <= r_clamp;
                        r_out.final_res    <= r_pos == '0;
                        r_frame            <= {r_frame[FRAME_BITS-2:0], 1'b0};
                        r_pos              <= r_pos - 1'b1;
                        if (r_pos == '0) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### rtl/core/dac_spi_frame_writer.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake                Payload
// request   in         push / full              i_item (t_in_item)
// result    out        pop / empty              o_result (t_result)
// config    in         psel, penable, pready    paddr, pwdata, prdata
//
// A rejected or unchanged request passes through the command queue and loads its one result
// into the output register; a raw-mode or saturated frame goes from the queue straight to
// shifting, while an unsaturated scaled frame first passes through the 12-step divider.
// Each result waits while the output register still holds an unread result.
// Synchronous active-low reset clears the last-sent levels and restores the register defaults.
// A two-entry command queue lets requests in while a frame is still shifting out.
module dac_spi_frame_writer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  dsfw_pkg::t_in_item i_item,
    output logic               empty,
    input  logic               pop,
    output dsfw_pkg::t_result  o_result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import dsfw_pkg::*;

    t_cfg r_cfg;
    t_cmd front_cmd;
    t_cmd q_cmd;
    logic front_wr;
    logic q_full;
    logic q_empty;
    logic q_rd;
    logic out_valid;
    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign full   = q_full;
    assign empty  = !out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.channel_count   <= 4'd1;
            r_cfg.reference_mv    <= 16'd3300;
            r_cfg.resolution_bits <= 4'd12;
            r_cfg.raw_code_mode   <= 1'b0;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_CHANNEL_COUNT: r_cfg.channel_count   <= pwdata[3:0];
                REG_REFERENCE_MV:  r_cfg.reference_mv    <= pwdata[15:0];
                REG_RESOLUTION:    r_cfg.resolution_bits <= pwdata[3:0];
                REG_RAW_MODE:      r_cfg.raw_code_mode   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_CHANNEL_COUNT: prdata = {28'd0, r_cfg.channel_count};
            REG_REFERENCE_MV:  prdata = {16'd0, r_cfg.reference_mv};
            REG_RESOLUTION:    prdata = {28'd0, r_cfg.resolution_bits};
            REG_RAW_MODE:      prdata = {31'd0, r_cfg.raw_code_mode};
            default:           prdata = '0;
        endcase
    end

    dsfw_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_push   (push),
        .i_item   (i_item),
        .i_q_full (q_full),
        .o_q_wr   (front_wr),
        .o_cmd    (front_cmd)
    );

    dsfw_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (front_wr),
        .i_data  (front_cmd),
        .i_rd    (q_rd),
        .o_data  (q_cmd),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    dsfw_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_cmd     (q_cmd),
        .i_q_empty (q_empty),
        .o_q_rd    (q_rd),
        .o_result  (o_result),
        .o_valid   (out_valid),
        .i_pop     (pop)
    );

endmodule
